>>> rtl/rjwm_pkg.sv
// Package for the rover joystick wheel mixer: field types, thresholds and
// the fixed reciprocal constants used by the truncating linear maps.
// No dependencies.
package rjwm_pkg;

  typedef logic signed [7:0] stick_t;
  typedef logic signed [6:0] angle_t;
  typedef logic signed [7:0] speed_t;

  localparam int unsigned NumAngles = 4;
  localparam int unsigned NumSpeeds = 6;

  // Axis thresholds on magnitudes.
  localparam logic [7:0] DeadZone    = 8'd20;  // |y| below this gives speed 0
  localparam logic [7:0] SpinMin     = 8'd80;  // |x| above this spins in place
  localparam logic [7:0] StraightMax = 8'd10;  // |x| up to this drives straight

  // Signed y thresholds that select front or rear steering.
  localparam stick_t FrontYMin = 8'sd20;
  localparam stick_t RearYMax  = -8'sd20;

  localparam angle_t AngleSpin    = 7'sd45;
  localparam angle_t AngleSpinNeg = -7'sd45;
  localparam angle_t AngleZero    = 7'sd0;
  localparam speed_t SpeedZero    = 8'sd0;

  // Forward speed: |y|*100/126 = |y|*50/63, floor via (p*16645) >> 20.
  localparam logic [12:0] SpeedScale = 13'd50;
  localparam logic [27:0] SpeedRecip = 28'd16645;
  localparam int unsigned SpeedShift = 20;

  // Spin speed: (|x|-80)*80/46 = d*40/23, floor via (p*2850) >> 16.
  localparam logic [10:0] SpinScale = 11'd40;
  localparam logic [22:0] SpinRecip = 23'd2850;

  // Steer angle: (|x|-10)*45/70 = d*9/14, floor via (p*4682) >> 16.
  localparam logic [9:0]  SteerScale = 10'd9;
  localparam logic [21:0] SteerRecip = 22'd4682;

  // Inner wheel: s*4/5, floor via (p*13108) >> 16 on the magnitude.
  localparam logic [8:0]  InnerScale = 9'd4;
  localparam logic [22:0] InnerRecip = 23'd13108;

  localparam int unsigned RecipShift = 16;

endpackage

>>> rtl/rjwm_stick_if.sv
// Request channel carrying one joystick sample (stick_x, stick_y).
// Depends on rjwm_pkg for the field types.
interface rjwm_stick_if;
  logic            valid;
  logic            ready;
  rjwm_pkg::stick_t stick_x;
  rjwm_pkg::stick_t stick_y;

  modport source (output valid, output stick_x, output stick_y, input ready);
  modport sink   (input valid, input stick_x, input stick_y, output ready);
endinterface

>>> rtl/rjwm_wheel_if.sv
// Request channel carrying one wheel command: four steering angles, six speeds.
// Depends on rjwm_pkg for the field types.
interface rjwm_wheel_if;
  logic             valid;
  logic             ready;
  rjwm_pkg::angle_t angle_wheel_one;
  rjwm_pkg::angle_t angle_wheel_two;
  rjwm_pkg::angle_t angle_wheel_three;
  rjwm_pkg::angle_t angle_wheel_four;
  rjwm_pkg::speed_t speed_wheel_one;
  rjwm_pkg::speed_t speed_wheel_two;
  rjwm_pkg::speed_t speed_wheel_three;
  rjwm_pkg::speed_t speed_wheel_four;
  rjwm_pkg::speed_t speed_wheel_five;
  rjwm_pkg::speed_t speed_wheel_six;

  modport source (
    output valid,
    output angle_wheel_one, output angle_wheel_two,
    output angle_wheel_three, output angle_wheel_four,
    output speed_wheel_one, output speed_wheel_two, output speed_wheel_three,
    output speed_wheel_four, output speed_wheel_five, output speed_wheel_six,
    input ready
  );
  modport sink (
    input valid,
    input angle_wheel_one, input angle_wheel_two,
    input angle_wheel_three, input angle_wheel_four,
    input speed_wheel_one, input speed_wheel_two, input speed_wheel_three,
    input speed_wheel_four, input speed_wheel_five, input speed_wheel_six,
    output ready
  );
endinterface

>>> rtl/rover_joystick_wheel_mixer.sv
// Rover joystick wheel mixer top level: joystick sample in, wheel command out.
// Depends on rjwm_pkg, rjwm_stick_if and rjwm_wheel_if.
//
//   channel   dir  modport  payload
//   stick_i   in   sink     stick_x, stick_y (8 bit signed)
//   wheel_o   out  source   angle_wheel_one..four (7 bit signed),
//                           speed_wheel_one..six (8 bit signed)
//
// One sample per cycle while wheel_o is not stalled; two register stages (input
// register, then the command register), the second one driving wheel_o.
// The command register doubles as the held wheel state: a steering sample with
// small y repeats it unchanged.
// Reset clears all held angles and speeds to zero and empties both stages.
// A stalled wheel_o holds the command; the input register keeps taking a
// sample whenever its content moves on in the same cycle.
module rover_joystick_wheel_mixer (
  input  logic               clk_i,
  input  logic               rst_ni,
  rjwm_stick_if.sink         stick_i,
  rjwm_wheel_if.source       wheel_o
);

  // Input stage
  logic             in_valid_q;
  rjwm_pkg::stick_t x_q;
  rjwm_pkg::stick_t y_q;

  // Command register, also the held wheel state
  logic             out_valid_q;
  rjwm_pkg::angle_t ang_q [rjwm_pkg::NumAngles];
  rjwm_pkg::speed_t spd_q [rjwm_pkg::NumSpeeds];
  rjwm_pkg::angle_t ang_d [rjwm_pkg::NumAngles];
  rjwm_pkg::speed_t spd_d [rjwm_pkg::NumSpeeds];

  logic advance;

  // Move the sample on when the command register is empty or being drained.
  assign advance       = in_valid_q && (!out_valid_q || wheel_o.ready);
  assign stick_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (stick_i.ready) begin
      in_valid_q <= stick_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stick_i.valid && stick_i.ready) begin
      x_q <= stick_i.stick_x;
      y_q <= stick_i.stick_y;
    end
  end

  // Magnitudes: -128 yields 128, which fits 8 unsigned bits.
  logic       x_neg, y_neg;
  logic [7:0] ax, ay;

  assign x_neg = x_q[7];
  assign y_neg = y_q[7];
  assign ax    = x_neg ? 8'(-x_q) : 8'(x_q);
  assign ay    = y_neg ? 8'(-y_q) : 8'(y_q);

  // Forward speed magnitude, zero inside the dead zone.
  logic [12:0] ay_scaled;
  logic [27:0] spd_prod;
  logic [6:0]  s_mag;
  logic [7:0]  s_pos;
  rjwm_pkg::speed_t s_val;

  assign ay_scaled = 13'(ay) * rjwm_pkg::SpeedScale;
  assign spd_prod  = 28'(ay_scaled) * rjwm_pkg::SpeedRecip;
  assign s_mag     = (ay < rjwm_pkg::DeadZone) ? 7'd0
                                               : spd_prod[rjwm_pkg::SpeedShift +: 7];
  assign s_pos     = {1'b0, s_mag};
  assign s_val     = y_neg ? rjwm_pkg::speed_t'(-s_pos) : rjwm_pkg::speed_t'(s_pos);

  // Inner wheel speed: truncate 4/5 of the magnitude, keep the sign of s.
  logic [8:0]  s_scaled;
  logic [22:0] inner_prod;
  logic [7:0]  i_pos;
  rjwm_pkg::speed_t i_val;

  assign s_scaled   = 9'(s_mag) * rjwm_pkg::InnerScale;
  assign inner_prod = 23'(s_scaled) * rjwm_pkg::InnerRecip;
  assign i_pos      = {1'b0, inner_prod[rjwm_pkg::RecipShift +: 7]};
  assign i_val      = y_neg ? rjwm_pkg::speed_t'(-i_pos) : rjwm_pkg::speed_t'(i_pos);

  // Spin speed, valid only when |x| is past the spin threshold.
  logic [7:0]  spin_off;
  logic [10:0] spin_scaled;
  logic [22:0] spin_prod;
  logic [7:0]  t_pos;
  rjwm_pkg::speed_t t_val, t_neg_val;

  assign spin_off    = ax - rjwm_pkg::SpinMin;
  assign spin_scaled = 11'(spin_off) * rjwm_pkg::SpinScale;
  assign spin_prod   = 23'(spin_scaled) * rjwm_pkg::SpinRecip;
  assign t_pos       = {1'b0, spin_prod[rjwm_pkg::RecipShift +: 7]};
  assign t_val       = x_neg ? rjwm_pkg::speed_t'(-t_pos) : rjwm_pkg::speed_t'(t_pos);
  assign t_neg_val   = rjwm_pkg::speed_t'(-t_val);

  // Steering angle, valid only in the middle band of |x|.
  logic [7:0]  steer_off;
  logic [9:0]  steer_scaled;
  logic [21:0] steer_prod;
  logic [6:0]  a_pos;
  rjwm_pkg::angle_t a_val;
  logic        a_gt_zero, a_lt_zero;

  assign steer_off    = ax - rjwm_pkg::StraightMax;
  assign steer_scaled = 10'(steer_off) * rjwm_pkg::SteerScale;
  assign steer_prod   = 22'(steer_scaled) * rjwm_pkg::SteerRecip;
  assign a_pos        = {1'b0, steer_prod[rjwm_pkg::RecipShift +: 6]};
  assign a_val        = x_neg ? rjwm_pkg::angle_t'(-a_pos) : rjwm_pkg::angle_t'(a_pos);
  assign a_gt_zero    = !x_neg && (a_pos != 7'd0);
  assign a_lt_zero    = x_neg && (a_pos != 7'd0);

  // Pick the mode and build the next command; default holds the last one.
  always_comb begin
    for (int k = 0; k < rjwm_pkg::NumAngles; k++) begin
      ang_d[k] = ang_q[k];
    end
    for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
      spd_d[k] = spd_q[k];
    end

    if (ax > rjwm_pkg::SpinMin) begin
      // Spin in place: diagonal angles, alternating speed signs.
      ang_d[0] = rjwm_pkg::AngleSpin;
      ang_d[1] = rjwm_pkg::AngleSpinNeg;
      ang_d[2] = rjwm_pkg::AngleSpinNeg;
      ang_d[3] = rjwm_pkg::AngleSpin;
      for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
        spd_d[k] = k[0] ? t_neg_val : t_val;
      end
    end else if (ax > rjwm_pkg::StraightMax) begin
      if (y_q > rjwm_pkg::FrontYMin) begin
        // Front steer: outer side keeps s, inner side slows.
        ang_d[0] = a_val;
        ang_d[1] = a_val;
        ang_d[2] = rjwm_pkg::AngleZero;
        ang_d[3] = rjwm_pkg::AngleZero;
        for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
          spd_d[k] = (k[0] ^ !a_gt_zero) ? i_val : s_val;
        end
      end else if (y_q < rjwm_pkg::RearYMax) begin
        // Rear steer, mirrored sense of the angle sign.
        ang_d[0] = rjwm_pkg::AngleZero;
        ang_d[1] = rjwm_pkg::AngleZero;
        ang_d[2] = a_val;
        ang_d[3] = a_val;
        for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
          spd_d[k] = (k[0] ^ !a_lt_zero) ? i_val : s_val;
        end
      end
      // Small y while steering: hold everything.
    end else begin
      // Straight: all angles zero, every wheel at s.
      for (int k = 0; k < rjwm_pkg::NumAngles; k++) begin
        ang_d[k] = rjwm_pkg::AngleZero;
      end
      for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
        spd_d[k] = s_val;
      end
    end
  end

  // The held state resets to zero, so it carries a reset here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int k = 0; k < rjwm_pkg::NumAngles; k++) begin
        ang_q[k] <= rjwm_pkg::AngleZero;
      end
      for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
        spd_q[k] <= rjwm_pkg::SpeedZero;
      end
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        for (int k = 0; k < rjwm_pkg::NumAngles; k++) begin
          ang_q[k] <= ang_d[k];
        end
        for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
          spd_q[k] <= spd_d[k];
        end
      end else if (wheel_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign wheel_o.valid             = out_valid_q;
  assign wheel_o.angle_wheel_one   = ang_q[0];
  assign wheel_o.angle_wheel_two   = ang_q[1];
  assign wheel_o.angle_wheel_three = ang_q[2];
  assign wheel_o.angle_wheel_four  = ang_q[3];
  assign wheel_o.speed_wheel_one   = spd_q[0];
  assign wheel_o.speed_wheel_two   = spd_q[1];
  assign wheel_o.speed_wheel_three = spd_q[2];
  assign wheel_o.speed_wheel_four  = spd_q[3];
  assign wheel_o.speed_wheel_five  = spd_q[4];
  assign wheel_o.speed_wheel_six   = spd_q[5];

  // Front pair either steers together or takes the spin diagonal.
  a_front_pair : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ang_q[0] == ang_q[1]) ||
    (ang_q[0] == rjwm_pkg::AngleSpin && ang_q[1] == rjwm_pkg::AngleSpinNeg))
    else $error("front wheel angles out of pattern");

  // Speeds always alternate between two values across the six wheels.
  a_speed_alt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spd_q[0] == spd_q[2]) && (spd_q[2] == spd_q[4]) &&
    (spd_q[1] == spd_q[3]) && (spd_q[3] == spd_q[5]))
    else $error("wheel speeds do not alternate");

  // A sample blocked by a full command register stays put.
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(x_q) && $stable(y_q))
    else $error("stalled sample lost or changed");

  // Every sample that moves on shows up as a command.
  a_advance_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("advanced sample produced no command");

endmodule

>>> sim/rover_joystick_wheel_mixer_tb.sv
// Self-checking bench for rover_joystick_wheel_mixer: joystick samples in, wheel commands out.
// Depends on rjwm_pkg, rjwm_stick_if, rjwm_wheel_if and the mixer RTL.
// A cycle-free predictor of the mixer checks every command field against its own held state.
module rover_joystick_wheel_mixer_tb;

  // Mixer thresholds in stick counts and map ends, then bench idle and run limits.
  localparam int AxisFull     = 126;
  localparam int SpeedFull    = 100;
  localparam int SpinEdge     = 80;
  localparam int SpinFull     = 80;
  localparam int SteerEdge    = 10;
  localparam int SteerFull    = 45;
  localparam int DeadBand     = 20;
  localparam int IdlePercent  = 30;
  localparam int CycleLimit   = 100000;
  localparam int SettleCycles = 8;

  // One wheel command, element 0 being wheel one.
  typedef struct packed {
    rjwm_pkg::angle_t [rjwm_pkg::NumAngles-1:0] angle;
    rjwm_pkg::speed_t [rjwm_pkg::NumSpeeds-1:0] speed;
  } wheel_cmd_t;

  logic clk;
  logic rst_n;

  rjwm_stick_if stick_bus ();
  rjwm_wheel_if wheel_bus ();

  rover_joystick_wheel_mixer u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .stick_i (stick_bus),
    .wheel_o (wheel_bus)
  );

  // Predicted wheel state: angles and speeds of the last command.
  int held_angle [rjwm_pkg::NumAngles];
  int held_speed [rjwm_pkg::NumSpeeds];

  wheel_cmd_t pending_cmds [$];

  int mismatch_count   = 0;
  int cycle_count      = 0;
  int send_idle_pct    = IdlePercent;
  int recv_idle_pct    = IdlePercent;
  int recv_hold_cycles = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Bound the run; a stuck handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Fill the speed slots alternately: odd wheels take p, even wheels q.
  function automatic void hold_speeds_alt(input int p, input int q);
    for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
      held_speed[k] = (k % 2 == 1) ? q : p;
    end
  endfunction

  // Work out the command for one accepted sample and queue it.
  function automatic void predict_command(input rjwm_pkg::stick_t x,
                                          input rjwm_pkg::stick_t y);
    int ax, ay, sx, sy, fwd, spin, steer, inner;
    wheel_cmd_t cmd;
    ax = (x < 0) ? -int'(x) : int'(x);
    ay = (y < 0) ? -int'(y) : int'(y);
    sx = (x < 0) ? -1 : 1;
    sy = (y < 0) ? -1 : 1;

    // Forward speed from y, zero inside the dead band.
    fwd = (ay < DeadBand) ? 0 : sy * (ay * SpeedFull / AxisFull);

    if (ax > SpinEdge) begin
      // Spin in place: fixed crab angles, y speed dropped.
      spin = sx * ((ax - SpinEdge) * SpinFull / (AxisFull - SpinEdge));
      held_angle[0] = SteerFull;
      held_angle[1] = -SteerFull;
      held_angle[2] = -SteerFull;
      held_angle[3] = SteerFull;
      hold_speeds_alt(spin, -spin);
    end else if (ax > SteerEdge) begin
      steer = sx * ((ax - SteerEdge) * SteerFull / (SpinEdge - SteerEdge));
      inner = fwd * 4 / 5;  // truncates toward zero
      if (int'(y) > DeadBand) begin
        // Front steer; a right turn slows the even side.
        held_angle[0] = steer;
        held_angle[1] = steer;
        held_angle[2] = 0;
        held_angle[3] = 0;
        if (steer > 0) hold_speeds_alt(fwd, inner);
        else           hold_speeds_alt(inner, fwd);
      end else if (int'(y) < -DeadBand) begin
        // Rear steer; the inner side flips with the angle sign.
        held_angle[0] = 0;
        held_angle[1] = 0;
        held_angle[2] = steer;
        held_angle[3] = steer;
        if (steer < 0) hold_speeds_alt(fwd, inner);
        else           hold_speeds_alt(inner, fwd);
      end
      // Steering with small y: keep the previous command.
    end else begin
      // Straight: all angles zero, every wheel at the forward speed.
      for (int k = 0; k < rjwm_pkg::NumAngles; k++) held_angle[k] = 0;
      hold_speeds_alt(fwd, fwd);
    end

    for (int k = 0; k < rjwm_pkg::NumAngles; k++)
      cmd.angle[k] = rjwm_pkg::angle_t'(held_angle[k]);
    for (int k = 0; k < rjwm_pkg::NumSpeeds; k++)
      cmd.speed[k] = rjwm_pkg::speed_t'(held_speed[k]);
    pending_cmds.push_back(cmd);
  endfunction

  // Offer one sample, with random gaps ahead of it, and hold it until taken.
  // Leave valid high on return; the next request or a drain lowers it.
  task automatic send_sample(input rjwm_pkg::stick_t x, input rjwm_pkg::stick_t y);
    while ($urandom_range(99) < send_idle_pct) begin
      stick_bus.valid <= 1'b0;
      @(posedge clk);
    end
    stick_bus.valid   <= 1'b1;
    stick_bus.stick_x <= x;
    stick_bus.stick_y <= y;
    do @(posedge clk); while (!stick_bus.ready);
    predict_command(x, y);
  endtask

  // Drop valid and wait until every predicted command has come back.
  task automatic wait_drained();
    stick_bus.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  // Draw one axis value: raw bytes, threshold neighbors, or a region band.
  function automatic rjwm_pkg::stick_t pick_axis();
    int mag;
    int sgn;
    sgn = $urandom_range(1) ? -1 : 1;
    case ($urandom_range(9))
      0, 1: return rjwm_pkg::stick_t'($urandom_range(255));
      2, 3: begin
        case ($urandom_range(13))
          0:  mag = 0;
          1:  mag = SteerEdge - 1;
          2:  mag = SteerEdge;
          3:  mag = SteerEdge + 1;
          4:  mag = DeadBand - 1;
          5:  mag = DeadBand;
          6:  mag = DeadBand + 1;
          7:  mag = SpinEdge - 1;
          8:  mag = SpinEdge;
          9:  mag = SpinEdge + 1;
          10: mag = AxisFull;
          11: mag = AxisFull + 1;
          12: return rjwm_pkg::stick_t'(-128);
          default: mag = 2 * DeadBand;
        endcase
      end
      default: begin
        case ($urandom_range(2))
          0:       mag = $urandom_range(SteerEdge);
          1:       mag = $urandom_range(SpinEdge, SteerEdge + 1);
          default: mag = $urandom_range(AxisFull + 1, SpinEdge + 1);
        endcase
      end
    endcase
    return rjwm_pkg::stick_t'(sgn * mag);
  endfunction

  // Output side: random stalls, plus a long hold-off when a test asks for it.
  initial begin
    wheel_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_hold_cycles > 0) begin
        wheel_bus.ready  <= 1'b0;
        recv_hold_cycles = recv_hold_cycles - 1;
      end else begin
        wheel_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare every accepted command with the oldest prediction.
  always @(posedge clk) begin : check_commands
    wheel_cmd_t got;
    wheel_cmd_t want;
    if (rst_n && wheel_bus.valid && wheel_bus.ready) begin
      got.angle[0] = wheel_bus.angle_wheel_one;
      got.angle[1] = wheel_bus.angle_wheel_two;
      got.angle[2] = wheel_bus.angle_wheel_three;
      got.angle[3] = wheel_bus.angle_wheel_four;
      got.speed[0] = wheel_bus.speed_wheel_one;
      got.speed[1] = wheel_bus.speed_wheel_two;
      got.speed[2] = wheel_bus.speed_wheel_three;
      got.speed[3] = wheel_bus.speed_wheel_four;
      got.speed[4] = wheel_bus.speed_wheel_five;
      got.speed[5] = wheel_bus.speed_wheel_six;
      if (pending_cmds.size() == 0) begin
        mismatch_count++;
        $display("%0t: command with nothing predicted, angle one %0d speed one %0d",
                 $time, $signed(got.angle[0]), $signed(got.speed[0]));
      end else begin
        want = pending_cmds.pop_front();
        for (int k = 0; k < rjwm_pkg::NumAngles; k++) begin
          if (got.angle[k] !== want.angle[k]) begin
            mismatch_count++;
            $display("%0t: angle of wheel %0d expected %0d actual %0d",
                     $time, k + 1, $signed(want.angle[k]), $signed(got.angle[k]));
          end
        end
        for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) begin
          if (got.speed[k] !== want.speed[k]) begin
            mismatch_count++;
            $display("%0t: speed of wheel %0d expected %0d actual %0d",
                     $time, k + 1, $signed(want.speed[k]), $signed(got.speed[k]));
          end
        end
      end
    end
  end

  // Straight driving: dead band edges and the full-scale y values.
  task automatic test_straight_drive();
    send_sample(8'sd0, 8'sd0);
    send_sample(8'sd0, 8'sd127);
    send_sample(8'sd0, -8'sd128);
    send_sample(8'sd10, 8'sd19);
    send_sample(-8'sd10, 8'sd20);
    send_sample(8'sd5, -8'sd20);
  endtask

  // Spin in place, including the -128 magnitude on x.
  task automatic test_spin_in_place();
    send_sample(-8'sd128, 8'sd0);
    send_sample(8'sd127, 8'sd100);
    send_sample(8'sd81, -8'sd128);
    send_sample(-8'sd81, 8'sd50);
  endtask

  // Front and rear steering, each turn direction and a zero angle.
  task automatic test_front_rear_steer();
    send_sample(8'sd80, 8'sd60);
    send_sample(-8'sd80, 8'sd21);
    send_sample(8'sd11, 8'sd127);
    send_sample(-8'sd45, -8'sd21);
    send_sample(8'sd45, -8'sd128);
    send_sample(-8'sd11, -8'sd100);
  endtask

  // Steering with small y repeats the held command, whatever it was.
  task automatic test_hold_on_small_y();
    send_sample(8'sd40, 8'sd80);
    send_sample(8'sd40, 8'sd20);
    send_sample(-8'sd60, -8'sd20);
    send_sample(8'sd100, 8'sd0);
    send_sample(8'sd30, 8'sd7);
    send_sample(8'sd0, 8'sd40);
    send_sample(-8'sd79, -8'sd1);
  endtask

  // Random samples; run a middle stretch with neither side idling.
  task automatic test_random_mix();
    for (int n = 0; n < 1000; n++) begin
      if (n == 300) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (n == 450) begin
        send_idle_pct = IdlePercent;
        recv_idle_pct = IdlePercent;
      end
      send_sample(pick_axis(), pick_axis());
    end
  endtask

  // Hold off the output for a long stretch while samples keep coming.
  task automatic test_output_backpressure();
    send_idle_pct    = 0;
    recv_hold_cycles = 60;
    for (int n = 0; n < 50; n++) send_sample(pick_axis(), pick_axis());
    send_idle_pct = IdlePercent;
  endtask

  // Pause the sender until every command is back, then resume.
  task automatic test_drain_pause();
    for (int n = 0; n < 30; n++) send_sample(pick_axis(), pick_axis());
    wait_drained();
    for (int n = 0; n < 30; n++) send_sample(pick_axis(), pick_axis());
  endtask

  initial begin
    for (int k = 0; k < rjwm_pkg::NumAngles; k++) held_angle[k] = 0;
    for (int k = 0; k < rjwm_pkg::NumSpeeds; k++) held_speed[k] = 0;
    rst_n             <= 1'b0;
    stick_bus.valid   <= 1'b0;
    stick_bus.stick_x <= 8'sd0;
    stick_bus.stick_y <= 8'sd0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_straight_drive();
    test_spin_in_place();
    test_front_rear_steer();
    test_hold_on_small_y();
    test_random_mix();
    test_output_backpressure();
    test_drain_pause();

    // Let the last commands out, then let the block sit quiet for SettleCycles.
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0 && pending_cmds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/rjwm_pkg.sv
rtl/rjwm_stick_if.sv
rtl/rjwm_wheel_if.sv
rtl/rover_joystick_wheel_mixer.sv
sim/rover_joystick_wheel_mixer_tb.sv
